// File: sv/assert_macros.svh
// assertion macros used by the checker file prt_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PRT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// checked at every edge, reset included
`define PRT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/prt_pkg.sv
// shared constants, codes and control structs of the pheromone route table
// no dependencies
package prt_pkg;

    localparam int DEST_ENTRIES_DEF    = 64;
    localparam int MAX_NEIGHBORS_DEF   = 8;
    localparam int PHERO_FRAC_BITS_DEF = 16;

    localparam int MODE_W    = 2;
    localparam int DEST_W    = 6;
    localparam int NB_W      = 8;
    localparam int PH_IN_W   = 17;
    localparam int DRAW_W    = 16;
    localparam int RATE_W    = 16;
    localparam int STATUS_W  = 3;

    localparam int DEST_LSB   = 0;
    localparam int NB_LSB     = DEST_LSB + DEST_W;
    localparam int PH_IN_LSB  = NB_LSB + NB_W;
    localparam int PARENT_LSB = PH_IN_LSB + PH_IN_W;
    localparam int DRAW_LSB   = PARENT_LSB + NB_W;
    localparam int S_FIELDS_W = DRAW_LSB + DRAW_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = NB_W;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEAD_END = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REDRAW   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic [1:0] HOP_ZERO   = 2'd0;
    localparam logic [1:0] HOP_PARENT = 2'd1;
    localparam logic [1:0] HOP_ENTRY  = 2'd2;

    typedef struct packed {
        logic                load_in;
        logic                add_wr;
        logic                ent_rd;
        logic                upd_mul;
        logic                upd_wr;
        logic                p1_step;
        logic                p2_init;
        logic                p2_step;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic [1:0]          out_hop;
    } prt_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              row_full;
        logic              idx_end;
        logic              p1_match;
        logic              dead_end;
        logic              redraw;
        logic              p2_hit;
    } prt_stat_t;

endpackage

// File: sv/prt_ctrl.sv
// controller state machine: sequences add, update and the two select passes
// depends on prt_pkg
module prt_ctrl
    import prt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  prt_stat_t stat,
    output prt_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CNT    = 4'd1;
    localparam logic [3:0] S_U_RD   = 4'd2;
    localparam logic [3:0] S_U_MUL  = 4'd3;
    localparam logic [3:0] S_U_WR   = 4'd4;
    localparam logic [3:0] S_P1_RD  = 4'd5;
    localparam logic [3:0] S_P1_CHK = 4'd6;
    localparam logic [3:0] S_EVAL   = 4'd7;
    localparam logic [3:0] S_P2_RD  = 4'd8;
    localparam logic [3:0] S_P2_CHK = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [1:0]          res_hop_reg, res_hop_next;
    logic                out_valid_reg, out_valid_next;

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_hop_next    = res_hop_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CNT;
                end
            end
            S_CNT: begin
                case (stat.mode)
                    MODE_ADD: begin
                        res_hop_next = HOP_ZERO;
                        state_next   = S_OUT;
                        if (stat.row_full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            cmd.add_wr      = 1'b1;
                            res_status_next = ST_DONE;
                        end
                    end
                    MODE_UPDATE: state_next = S_U_RD;
                    MODE_SELECT: state_next = S_P1_RD;
                    default: begin
                        res_status_next = ST_DONE;
                        res_hop_next    = HOP_ZERO;
                        state_next      = S_OUT;
                    end
                endcase
            end
            S_U_RD: begin
                if (stat.idx_end) begin
                    res_status_next = ST_DONE;
                    res_hop_next    = HOP_ZERO;
                    state_next      = S_OUT;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_U_MUL;
                end
            end
            S_U_MUL: begin
                cmd.upd_mul = 1'b1;
                state_next  = S_U_WR;
            end
            S_U_WR: begin
                cmd.upd_wr = 1'b1;
                state_next = S_U_RD;
            end
            S_P1_RD: begin
                if (stat.idx_end) begin
                    state_next = S_EVAL;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_P1_CHK;
                end
            end
            S_P1_CHK: begin
                cmd.p1_step = 1'b1;
                state_next  = stat.p1_match ? S_EVAL : S_P1_RD;
            end
            S_EVAL: begin
                if (stat.dead_end) begin
                    res_status_next = ST_DEAD_END;
                    res_hop_next    = HOP_PARENT;
                    state_next      = S_OUT;
                end else if (stat.redraw) begin
                    res_status_next = ST_REDRAW;
                    res_hop_next    = HOP_ZERO;
                    state_next      = S_OUT;
                end else begin
                    cmd.p2_init = 1'b1;
                    state_next  = S_P2_RD;
                end
            end
            S_P2_RD: begin
                if (stat.idx_end) begin
                    res_status_next = ST_NO_ROUTE;
                    res_hop_next    = HOP_ZERO;
                    state_next      = S_OUT;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_P2_CHK;
                end
            end
            S_P2_CHK: begin
                cmd.p2_step = 1'b1;
                if (stat.p2_hit) begin
                    res_status_next = ST_DONE;
                    res_hop_next    = HOP_ENTRY;
                    state_next      = S_OUT;
                end else begin
                    state_next = S_P2_RD;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = res_status_reg;
                    cmd.out_hop    = res_hop_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_DONE;
            res_hop_reg    <= HOP_ZERO;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_hop_reg    <= res_hop_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// File: sv/prt_dp.sv
// datapath: table memories, row counts, update multiplier, select sums, result register
// depends on prt_pkg; driven by prt_ctrl
module prt_dp
    import prt_pkg::*;
#(
    parameter int DEST_ENTRIES    = DEST_ENTRIES_DEF,
    parameter int MAX_NEIGHBORS   = MAX_NEIGHBORS_DEF,
    parameter int PHERO_FRAC_BITS = PHERO_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [RATE_W-1:0]    cfg_wr_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]    s_tuser,
    input  prt_cmd_t             cmd,
    output prt_stat_t            stat,
    output logic [NB_W-1:0]      hop_out,
    output logic [STATUS_W-1:0]  status_out
);

    localparam int SLOTS  = DEST_ENTRIES * MAX_NEIGHBORS;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W  = $clog2(DEST_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int FB     = PHERO_FRAC_BITS;
    localparam int PH_W   = FB + 1;
    localparam int SUM_W  = PH_W + CNT_W;
    localparam int CMP_W  = (PH_IN_W > PH_W) ? PH_IN_W : PH_W;
    localparam int PROD_W = 2 * PH_W;
    localparam int DW     = FB + DRAW_W;
    localparam logic [PH_W-1:0]  ONE_PH  = PH_W'(1) << FB;
    localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(ONE_PH);
    localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(ONE_PH);

    // request fields
    logic [DEST_W-1:0]  s_dest;
    logic [NB_W-1:0]    s_nb;
    logic [PH_IN_W-1:0] s_ph_in;
    logic [NB_W-1:0]    s_parent;
    logic [DRAW_W-1:0]  s_draw;
    logic [ROW_W-1:0]   s_row;
    logic [DW-1:0]      draw_wide;
    logic [FB-1:0]      draw_al;
    logic [PH_W-1:0]    ph_in_sat;

    assign s_dest    = s_tdata[DEST_LSB +: DEST_W];
    assign s_nb      = s_tdata[NB_LSB +: NB_W];
    assign s_ph_in   = s_tdata[PH_IN_LSB +: PH_IN_W];
    assign s_parent  = s_tdata[PARENT_LSB +: NB_W];
    assign s_draw    = s_tdata[DRAW_LSB +: DRAW_W];
    assign s_row     = ROW_W'(s_dest);
    assign draw_wide = DW'(s_draw);
    assign ph_in_sat = (CMP_W'(s_ph_in) > ONE_CMP) ? ONE_PH : PH_W'(s_ph_in);

    generate
        if (FB >= DRAW_W) begin : g_draw_up
            assign draw_al = FB'(draw_wide << (FB - DRAW_W));
        end else begin : g_draw_down
            assign draw_al = FB'(draw_wide >> (DRAW_W - FB));
        end
    endgenerate

    logic [MODE_W-1:0]   mode_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                row_ok_reg;
    logic [NB_W-1:0]     nb_reg;
    logic [NB_W-1:0]     parent_reg;
    logic [PH_W-1:0]     ph_in_reg;
    logic [FB-1:0]       draw_reg;
    logic [CNT_W-1:0]    cnt_rd_reg;
    logic                cnt_vld_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [PH_W-1:0]     ent_ph_reg;
    logic [NB_W-1:0]     ent_nb_reg;
    logic [SUM_W-1:0]    lo_reg, hi_reg, acc_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PH_W-1:0]     upd_ph_reg;
    logic                upd_match_reg;
    logic [NB_W-1:0]     hop_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [DEST_ENTRIES-1:0] row_vld_reg;

    logic [PH_W-1:0]  ph_mem  [SLOTS];
    logic [NB_W-1:0]  nb_mem  [SLOTS];
    logic [CNT_W-1:0] cnt_mem [DEST_ENTRIES];

    logic [CNT_W-1:0]  cnt_eff;
    logic [ADDR_W-1:0] row_base, ent_addr, add_addr, wr_addr;
    logic [PH_W-1:0]   rate_sat, ent_ph_sat, mul_a, mul_b, prod_sh, new_ph, ph_wdata;
    logic [PH_W:0]     upd_sum;
    logic              ent_match_nb, ph_we;
    logic [SUM_W-1:0]  ph_ext, hi_eff, draw_ext, acc_sum;

    assign cnt_eff  = (row_ok_reg && cnt_vld_reg) ? cnt_rd_reg : '0;
    assign row_base = ADDR_W'(row_reg) * ADDR_W'(MAX_NEIGHBORS);
    assign ent_addr = row_base + ADDR_W'(idx_reg);
    assign add_addr = row_base + ADDR_W'(cnt_eff);
    assign wr_addr  = cmd.add_wr ? add_addr : ent_addr;

    // update arithmetic
    assign rate_sat     = (CMP_W'(rate_reg) > ONE_CMP) ? ONE_PH : PH_W'(rate_reg);
    assign ent_ph_sat   = (ent_ph_reg > ONE_PH) ? ONE_PH : ent_ph_reg;
    assign ent_match_nb = (ent_nb_reg == nb_reg);
    assign mul_a        = ent_match_nb ? rate_sat : (ONE_PH - rate_sat);
    assign mul_b        = ent_match_nb ? (ONE_PH - ent_ph_sat) : ent_ph_sat;
    assign prod_sh      = PH_W'(prod_reg >> FB);
    assign upd_sum      = upd_match_reg ? ({1'b0, upd_ph_reg} + {1'b0, prod_sh})
                                        : {1'b0, prod_sh};
    assign new_ph       = (upd_sum > {1'b0, ONE_PH}) ? ONE_PH : upd_sum[PH_W-1:0];
    assign ph_we        = cmd.add_wr | cmd.upd_wr;
    assign ph_wdata     = cmd.add_wr ? ph_in_reg : new_ph;

    // select arithmetic
    assign ph_ext   = SUM_W'(ent_ph_reg);
    assign hi_eff   = (hi_reg == '0) ? ONE_SUM : hi_reg;
    assign draw_ext = SUM_W'(draw_reg);
    assign acc_sum  = acc_reg + ph_ext;

    assign stat.mode     = mode_reg;
    assign stat.row_full = !row_ok_reg || (cnt_eff >= CNT_W'(MAX_NEIGHBORS));
    assign stat.idx_end  = (idx_reg == cnt_eff);
    assign stat.p1_match = (ent_nb_reg == parent_reg);
    assign stat.dead_end = (lo_reg == '0) && (hi_eff == ONE_SUM);
    assign stat.redraw   = (draw_ext >= lo_reg) && (draw_ext < hi_eff);
    assign stat.p2_hit   = (draw_ext >= acc_reg) && (draw_ext < acc_sum);

    always_ff @(posedge aclk) begin
        if (ph_we) begin
            ph_mem[wr_addr] <= ph_wdata;
        end
        if (cmd.add_wr) begin
            nb_mem[wr_addr] <= nb_reg;
        end
        if (cmd.ent_rd) begin
            ent_ph_reg <= ph_mem[ent_addr];
            ent_nb_reg <= nb_mem[ent_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_wr) begin
            cnt_mem[row_reg] <= cnt_eff + CNT_W'(1);
        end
        if (cmd.load_in) begin
            cnt_rd_reg <= cnt_mem[s_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rate_reg    <= '0;
        end else begin
            if (cmd.add_wr) begin
                row_vld_reg[row_reg] <= 1'b1;
            end
            if (cfg_wr_en) begin
                rate_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg    <= s_tuser;
            row_reg     <= s_row;
            row_ok_reg  <= (int'(s_dest) < DEST_ENTRIES);
            nb_reg      <= s_nb;
            parent_reg  <= s_parent;
            ph_in_reg   <= ph_in_sat;
            draw_reg    <= draw_al;
            cnt_vld_reg <= row_vld_reg[s_row];
            idx_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
        end
        if (cmd.upd_mul) begin
            prod_reg      <= PROD_W'(mul_a) * PROD_W'(mul_b);
            upd_ph_reg    <= ent_ph_sat;
            upd_match_reg <= ent_match_nb;
        end
        if (cmd.upd_wr || cmd.p1_step || cmd.p2_step) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (cmd.p1_step) begin
            if (stat.p1_match) begin
                hi_reg <= lo_reg + ph_ext;
            end else begin
                lo_reg <= lo_reg + ph_ext;
            end
        end
        if (cmd.p2_init) begin
            idx_reg <= '0;
            acc_reg <= '0;
        end
        if (cmd.p2_step) begin
            acc_reg <= acc_sum;
        end
        if (cmd.out_load) begin
            status_reg <= cmd.out_status;
            case (cmd.out_hop)
                HOP_PARENT: hop_reg <= parent_reg;
                HOP_ENTRY:  hop_reg <= ent_nb_reg;
                default:    hop_reg <= '0;
            endcase
        end
    end

    assign hop_out    = hop_reg;
    assign status_out = status_reg;

endmodule

// File: sv/pheromone_route_table_top.sv
// top level of the pheromone route table: request and result streams, config write
// depends on prt_pkg, prt_ctrl, prt_dp
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tuser: mode; tdata: dest, neighbor, pheromone, parent, draw
// m_       out  m_tvalid/m_tready  tuser: status; tdata: next_hop
// cfg_     in   cfg_wr_en          cfg_wr_data: reinforce rate
//
// one request at a time; add and no-op go from accept through S_CNT to S_OUT, which loads the result
// update reads, scales and writes back each entry of the row in turn; select reads entries
// one at a time in a parent pass and, unless a dead end or redraw ends it, a draw pass
// the result register lets the next request in while a result waits on m_tready
// synchronous active-low reset clears row counts, rate and control; no clearing pass
module pheromone_route_table_top
    import prt_pkg::*;
#(
    parameter int DEST_ENTRIES    = DEST_ENTRIES_DEF,
    parameter int MAX_NEIGHBORS   = MAX_NEIGHBORS_DEF,
    parameter int PHERO_FRAC_BITS = PHERO_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [RATE_W-1:0]    cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dest_index, neighbor_addr, pheromone_in, parent_addr, random_draw
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [MODE_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_hop
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]  m_tuser
);

    prt_cmd_t  cmd;
    prt_stat_t stat;

    prt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prt_dp #(
        .DEST_ENTRIES    (DEST_ENTRIES),
        .MAX_NEIGHBORS   (MAX_NEIGHBORS),
        .PHERO_FRAC_BITS (PHERO_FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .hop_out     (m_tdata),
        .status_out  (m_tuser)
    );

endmodule

// File: sv/prt_checker.sv
// port-level assertions for the pheromone route table, bound to the top level
// depends on prt_pkg and assert_macros.svh
`include "assert_macros.svh"

module prt_checker
    import prt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    `PRT_ASSERT_ALWAYS(a_reset_no_result, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `PRT_ASSERT(a_result_held, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `PRT_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> m_tuser <= ST_FULL, "bad status")
    `PRT_ASSERT(a_hop_zero, aclk, aresetn, m_tvalid && m_tuser != ST_DONE && m_tuser != ST_DEAD_END |-> m_tdata == '0, "hop not zero")
    `PRT_ASSERT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second request taken")

endmodule

bind pheromone_route_table_top prt_checker u_prt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
